### rtl/core/ldd_pkg.sv
// Shared types, constants and the text helper for the decimal row updater.
package ldd_pkg;

  localparam int VAL_W           = 32;
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int CONV_STEPS      = VAL_W;
  localparam int COLUMN_W        = 4;
  localparam int GLYPH_W         = 7;
  localparam int DEF_ROW_COLUMNS = 16;
  // widest text is "-214748364.8", so the terminator never lies past this column
  localparam int MAX_TEXT_COL    = 12;

  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TERM  = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic load;
    logic conv;
    logic walk;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic walk_done;
    logic flush_done;
  } ctrl_sts_t;

  // Character at one column of the padded text for a BCD magnitude and sign.
  function automatic logic [7:0] text_char(input logic [BCD_W-1:0] bcd, input logic neg,
                                           input logic [5:0] col);
    logic [5:0] nd;
    logic [5:0] len;
    logic [5:0] idx;
    logic [3:0] dg;
    logic [7:0] ch;
    nd = 6'd1;
    for (int k = 1; k < BCD_DIGITS; k++) begin
      if (bcd[4*k +: 4] != 4'd0) nd = 6'(k + 1);
    end
    len = nd + {5'd0, neg};
    idx = nd - 6'd1 - col + {5'd0, neg};
    dg  = 4'd0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (idx == 6'(k)) dg = bcd[4*k +: 4];
    end
    if (neg && col == 6'd0) begin
      ch = CH_MINUS;
    end else if (col + 6'd1 < len) begin
      ch = CH_ZERO | {4'd0, dg};
    end else if (col == len - 6'd1) begin
      ch = CH_POINT;
    end else if (col == len) begin
      ch = CH_ZERO | {4'd0, bcd[3:0]};
    end else if (col == len + 6'd1) begin
      ch = CH_TERM;
    end else begin
      ch = CH_SPACE;
    end
    return ch;
  endfunction

endpackage

### rtl/core/ldd_channels.sv
// Handshake channels: input word and result word.
interface ldd_in_if import ldd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] angle_tenths;
  logic signed [VAL_W-1:0] velocity_tenths;

  modport source (output valid, output angle_tenths, output velocity_tenths, input ready);
  modport sink   (input valid, input angle_tenths, input velocity_tenths, output ready);
endinterface

interface ldd_out_if import ldd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                row_select;
  logic [COLUMN_W-1:0] column;
  logic [GLYPH_W-1:0]  glyph;
  logic                last_write;

  modport source (output valid, output row_select, output column, output glyph,
                  output last_write, input ready);
  modport sink   (input valid, input row_select, input column, input glyph,
                  input last_write, output ready);
endinterface

### rtl/core/lcd_decimal_diff_update.sv
// Top level of the two-row decimal display updater.
//
//   channel  dir  word                                    handshake
//   in_ch    in   angle_tenths, velocity_tenths (s32)     valid/ready
//   out_ch   out  row_select, column, glyph, last_write   valid/ready
//
// An item is loaded, converted one bit per cycle, walked column by column over
// both rows (at most 2*ROW_COLUMNS columns) and then flushed.
// Each changed column gives one word; walk and flush stall only while the
// output register is full and the consumer holds ready low.
// Reset (rst_n low, synchronous) sets both stored rows to spaces at once.
module lcd_decimal_diff_update import ldd_pkg::*; #(
  parameter int ROW_COLUMNS = DEF_ROW_COLUMNS
) (
  input  logic        clk,
  input  logic        rst_n,
  ldd_in_if.sink      in_ch,
  ldd_out_if.source   out_ch
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ldd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ldd_datapath #(
    .ROW_COLUMNS (ROW_COLUMNS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .angle_tenths    (in_ch.angle_tenths),
    .velocity_tenths (in_ch.velocity_tenths),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_row_select  (out_ch.row_select),
    .out_column      (out_ch.column),
    .out_glyph       (out_ch.glyph),
    .out_last_write  (out_ch.last_write)
  );

endmodule

### rtl/core/ldd_bcd_conv.sv
// Shift-and-add-3 binary to BCD converter, one bit per step, with sign split off.
module ldd_bcd_conv import ldd_pkg::*; (
  input  logic                    clk,
  input  logic                    load,
  input  logic                    step,
  input  logic signed [VAL_W-1:0] value,
  output logic [BCD_W-1:0]        bcd,
  output logic                    neg
);

  logic [VAL_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic             neg_r, neg_nxt;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3 : bcd_r[4*d +: 4];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    if (load) begin
      neg_nxt = value[VAL_W-1];
      // most negative value negates onto itself, which is the right magnitude unsigned
      bin_nxt = value[VAL_W-1] ? VAL_W'(-value) : VAL_W'(value);
      bcd_nxt = '0;
    end else if (step) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[VAL_W-1]};
      bin_nxt = {bin_r[VAL_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign bcd = bcd_r;
  assign neg = neg_r;

endmodule

### rtl/core/ldd_ctrl.sv
// Sequencer: load, convert, walk both rows, flush the held word.
module ldd_ctrl import ldd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output ctrl_cmd_t cmd,
  input  ctrl_sts_t sts
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_done) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.flush_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/ldd_datapath.sv
// Converters, stored rows, column walker, held word and output register.
module ldd_datapath import ldd_pkg::*; #(
  parameter int ROW_COLUMNS = DEF_ROW_COLUMNS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output ctrl_sts_t               sts,
  input  logic signed [VAL_W-1:0] angle_tenths,
  input  logic signed [VAL_W-1:0] velocity_tenths,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_row_select,
  output logic [COLUMN_W-1:0]     out_column,
  output logic [GLYPH_W-1:0]      out_glyph,
  output logic                    out_last_write
);

  localparam int COL_W  = $clog2(ROW_COLUMNS);
  localparam int STEP_W = $clog2(CONV_STEPS);

  logic [BCD_W-1:0] vel_bcd, ang_bcd;
  logic             vel_neg, ang_neg;

  ldd_bcd_conv u_vel_conv (
    .clk   (clk),
    .load  (cmd.load),
    .step  (cmd.conv),
    .value (velocity_tenths),
    .bcd   (vel_bcd),
    .neg   (vel_neg)
  );

  ldd_bcd_conv u_ang_conv (
    .clk   (clk),
    .load  (cmd.load),
    .step  (cmd.conv),
    .value (angle_tenths),
    .bcd   (ang_bcd),
    .neg   (ang_neg)
  );

  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [7:0]          vel_row_r [ROW_COLUMNS];
  logic [7:0]          vel_row_nxt [ROW_COLUMNS];
  logic [7:0]          ang_row_r [ROW_COLUMNS];
  logic [7:0]          ang_row_nxt [ROW_COLUMNS];
  logic [COL_W-1:0]    col_r, col_nxt;
  logic                row_r, row_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic                pend_row_r, pend_row_nxt;
  logic [COLUMN_W-1:0] pend_col_r, pend_col_nxt;
  logic [GLYPH_W-1:0]  pend_glyph_r, pend_glyph_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_row_r, out_row_nxt;
  logic [COLUMN_W-1:0] out_col_r, out_col_nxt;
  logic [GLYPH_W-1:0]  out_glyph_r, out_glyph_nxt;
  logic                out_last_r, out_last_nxt;

  logic [7:0]         stored_ch, new_ch;
  logic [GLYPH_W-1:0] show_glyph;
  logic               diff, is_term, row_end, slot_free, walk_go;

  assign stored_ch  = row_r ? ang_row_r[col_r] : vel_row_r[col_r];
  assign new_ch     = row_r ? text_char(ang_bcd, ang_neg, 6'(col_r))
                            : text_char(vel_bcd, vel_neg, 6'(col_r));
  assign diff       = stored_ch != new_ch;
  assign is_term    = new_ch == CH_TERM;
  assign show_glyph = is_term ? CH_SPACE[GLYPH_W-1:0] : new_ch[GLYPH_W-1:0];
  assign row_end    = (diff && is_term) || (col_r == COL_W'(ROW_COLUMNS - 1));
  assign slot_free  = !out_valid_r || out_ready;
  // a new difference pushes the held word out, so it waits for a free slot
  assign walk_go    = cmd.walk && !(diff && pend_valid_r && !slot_free);

  assign sts.conv_done  = cmd.conv && (step_r == STEP_W'(CONV_STEPS - 1));
  assign sts.walk_done  = walk_go && row_end && row_r;
  assign sts.flush_done = !pend_valid_r || slot_free;

  always_comb begin
    step_nxt       = step_r;
    vel_row_nxt    = vel_row_r;
    ang_row_nxt    = ang_row_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    pend_valid_nxt = pend_valid_r;
    pend_row_nxt   = pend_row_r;
    pend_col_nxt   = pend_col_r;
    pend_glyph_nxt = pend_glyph_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_glyph_nxt  = out_glyph_r;
    out_last_nxt   = out_last_r;

    if (cmd.load) begin
      step_nxt = '0;
      col_nxt  = '0;
      row_nxt  = 1'b0;
    end
    if (cmd.conv) step_nxt = step_r + STEP_W'(1);

    if (walk_go) begin
      if (diff) begin
        if (row_r) ang_row_nxt[col_r] = new_ch;
        else       vel_row_nxt[col_r] = new_ch;
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = pend_row_r;
          out_col_nxt   = pend_col_r;
          out_glyph_nxt = pend_glyph_r;
          out_last_nxt  = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_row_nxt   = row_r;
        pend_col_nxt   = col_r[COLUMN_W-1:0];
        pend_glyph_nxt = show_glyph;
      end
      if (row_end) begin
        col_nxt = '0;
        row_nxt = 1'b1;
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    // the held word is the last of the item once the walk is over
    if (cmd.flush && pend_valid_r && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_row_nxt    = pend_row_r;
      out_col_nxt    = pend_col_r;
      out_glyph_nxt  = pend_glyph_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROW_COLUMNS; i++) begin
        vel_row_r[i] <= CH_SPACE;
        ang_row_r[i] <= CH_SPACE;
      end
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
      col_r        <= '0;
      row_r        <= 1'b0;
    end else begin
      vel_row_r    <= vel_row_nxt;
      ang_row_r    <= ang_row_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      step_r       <= step_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_row_r   <= pend_row_nxt;
    pend_col_r   <= pend_col_nxt;
    pend_glyph_r <= pend_glyph_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_glyph_r  <= out_glyph_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_row_select = out_row_r;
  assign out_column     = out_col_r;
  assign out_glyph      = out_glyph_r;
  assign out_last_write = out_last_r;

endmodule

### rtl/core/ldd_checker.sv
// Port-level checks for the display updater, bound to the top level.
module ldd_checker import ldd_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_row_select,
  input logic [COLUMN_W-1:0] out_column,
  input logic [GLYPH_W-1:0]  out_glyph,
  input logic                out_last_write
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_row_select, out_column, out_glyph, out_last_write}))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready high right after an accepted word");

  // a word that is not the last means the item is still being walked or flushed
  a_mid_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_write |-> !in_ready)
    else $error("input ready while an item still has words to give");

  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_column <= COLUMN_W'(MAX_TEXT_COL))
    else $error("write beyond the longest possible text");

endmodule

bind lcd_decimal_diff_update ldd_checker u_ldd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_row_select (out_ch.row_select),
  .out_column     (out_ch.column),
  .out_glyph      (out_ch.glyph),
  .out_last_write (out_ch.last_write)
);
